>>> hw/rtl/fit_policy_segment_allocator_assert.svh
// Assertion macros for the segment allocator.
`ifndef FIT_POLICY_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_SEGMENT_ALLOCATOR_ASSERT_SVH
// Check a property on every clock edge outside reset.
`define FPSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check an implication whose consequent holds in the cycle after the antecedent.
`define FPSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`endif

>>> hw/rtl/fpsa_pkg.sv
// Shared types and constants for the segment allocator.
package fpsa_pkg;
  localparam int unsigned Entries  = 16;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned CntW     = $clog2(Entries + 1);
  localparam int unsigned AddrW    = 16;

  localparam logic [1:0] RegPoolSize = 2'd0;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CmdAlloc   = 2'd0;
  localparam cmd_t CmdRelease = 2'd1;
  localparam cmd_t CmdInit    = 2'd2;
  localparam cmd_t CmdNone    = 2'd3;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;
  localparam logic [1:0] FitWorst = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t StOk       = 3'd0;
  localparam status_t StNoFit    = 3'd1;
  localparam status_t StBadMode  = 3'd2;
  localparam status_t StNotFound = 3'd3;
  localparam status_t StFull     = 3'd4;

  typedef enum logic [2:0] {
    StIdle, StScan, StCommit, StShift, StAppend, StOut
  } state_e;

  // Compare unit request and response.
  typedef struct packed {
    logic [1:0]       mode;
    logic [AddrW-1:0] key;
    logic [AddrW-1:0] entry;
    logic [AddrW-1:0] best;
    logic             have;
  } cmp_req_t;

  typedef struct packed {
    logic hit;
    logic take;
  } cmp_rsp_t;
endpackage

>>> hw/rtl/fpsa_cmp.sv
// Shared compare unit: judges one table entry against the key and the current pick.
module fpsa_cmp (
  input  fpsa_pkg::cmp_req_t req_i,
  input  logic               lookup_i,
  output fpsa_pkg::cmp_rsp_t rsp_o
);
  logic fits;
  always_comb begin
    fits = lookup_i ? (req_i.entry == req_i.key) : (req_i.entry >= req_i.key);
    rsp_o.hit  = fits;
    rsp_o.take = 1'b0;
    if (fits) begin
      if (!req_i.have || lookup_i) begin
        rsp_o.take = 1'b1;
      end else begin
        case (req_i.mode)
          fpsa_pkg::FitBest:  rsp_o.take = req_i.entry < req_i.best;
          fpsa_pkg::FitWorst: rsp_o.take = req_i.entry > req_i.best;
          default:            rsp_o.take = 1'b0;
        endcase
      end
    end
  end
endmodule

>>> hw/rtl/fit_policy_segment_allocator.sv
// Top level: sequencer, segment tables and output register of the allocator.
// Usage: write pool_size over APB (address 0) while idle, then send commands
// on the s_axis channel: tdata holds command, request_size, fit_mode, address.
// Each item gives one result on m_axis: status and block_base.
// An allocate scans the free table one entry per cycle through one shared
// compare unit, then removes the picked entry by shifting the entries above
// it down one per cycle, then appends. A release scans the used table the
// same way. The block returns to idle after each result before the next
// item is taken.
// One item is in work at a time: s_axis_tready is low from acceptance until
// the result has been taken. If the receiver stalls, the result is held in
// the output register and no new item is taken.
// Reset sets pool_size to 65535 and the tables to one free segment
// [0, 65535) with an empty used table; no clearing pass is needed.
`include "fit_policy_segment_allocator_assert.svh"
module fit_policy_segment_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [17:2] request_size, [19:18] fit_mode, [35:20] address, zero pad
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [18:3] block_base, zero pad
  output logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned W = fpsa_pkg::AddrW;
  localparam int unsigned CW = fpsa_pkg::CntW;
  localparam int unsigned IW = fpsa_pkg::IdxW;
  localparam int unsigned N = fpsa_pkg::Entries;

  fpsa_pkg::state_e state_q, state_d;
  logic [W-1:0] pool_q;
  logic [W-1:0] fb_q [N], fl_q [N], ub_q [N], ul_q [N];
  logic [CW-1:0] fcnt_q, ucnt_q, idx_q, pick_q;
  logic have_q;
  logic [W-1:0] best_q;
  fpsa_pkg::cmd_t cmd_q;
  logic [W-1:0] req_q, addr_q;
  logic [1:0] mode_q;
  logic [W-1:0] sel_base_q, sel_len_q;
  logic [2:0] st_q;
  logic [W-1:0] obase_q;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == fpsa_pkg::RegPoolSize);
  assign prdata = (paddr == fpsa_pkg::RegPoolSize) ? {16'd0, pool_q} : 32'd0;

  logic rel;
  logic [CW-1:0] cnt;
  logic [W-1:0] ent;
  fpsa_pkg::cmp_req_t creq;
  fpsa_pkg::cmp_rsp_t crsp;
  assign rel = (cmd_q == fpsa_pkg::CmdRelease);
  assign cnt = rel ? ucnt_q : fcnt_q;
  assign ent = rel ? ub_q[idx_q[IW-1:0]] : fl_q[idx_q[IW-1:0]];
  always_comb begin
    creq.mode  = mode_q;
    creq.key   = rel ? addr_q : req_q;
    creq.entry = ent;
    creq.best  = best_q;
    creq.have  = have_q;
  end
  fpsa_cmp u_cmp (.req_i(creq), .lookup_i(rel), .rsp_o(crsp));

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == fpsa_pkg::StIdle);
  assign m_axis_tvalid = (state_q == fpsa_pkg::StOut);
  assign m_axis_tdata = {5'd0, obase_q, st_q};

  logic scan_end;
  assign scan_end = (idx_q >= cnt) || (have_q && (rel || mode_q == fpsa_pkg::FitFirst));

  always_comb begin
    state_d = state_q;
    case (state_q)
      fpsa_pkg::StIdle:   if (acc) state_d = fpsa_pkg::StScan;
      fpsa_pkg::StScan:   if (cmd_q == fpsa_pkg::CmdInit || cmd_q == fpsa_pkg::CmdNone)
                            state_d = fpsa_pkg::StOut;
                          else if (!rel && (mode_q > fpsa_pkg::FitWorst || req_q == '0))
                            state_d = fpsa_pkg::StOut;
                          else if (scan_end) state_d = fpsa_pkg::StCommit;
      fpsa_pkg::StCommit: if (!have_q) state_d = fpsa_pkg::StOut;
                          else if (rel ? (fcnt_q >= CW'(N)) : (ucnt_q >= CW'(N)))
                            state_d = fpsa_pkg::StOut;
                          else state_d = fpsa_pkg::StShift;
      fpsa_pkg::StShift:  if (idx_q + CW'(1) >= cnt) state_d = fpsa_pkg::StAppend;
      fpsa_pkg::StAppend: state_d = fpsa_pkg::StOut;
      fpsa_pkg::StOut:    if (m_axis_tready) state_d = fpsa_pkg::StIdle;
      default:            state_d = fpsa_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpsa_pkg::StIdle;
      pool_q  <= '1;
      fcnt_q  <= CW'(1);
      ucnt_q  <= '0;
      fb_q[0] <= '0;
      fl_q[0] <= '1;
      st_q    <= fpsa_pkg::StOk;
      obase_q <= '0;
      idx_q   <= '0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) pool_q <= pwdata[W-1:0];
      case (state_q)
        fpsa_pkg::StIdle: if (acc) begin
          cmd_q   <= s_axis_tdata[1:0];
          req_q   <= s_axis_tdata[17:2];
          mode_q  <= s_axis_tdata[19:18];
          addr_q  <= s_axis_tdata[35:20];
          idx_q   <= '0;
          have_q  <= 1'b0;
          st_q    <= fpsa_pkg::StOk;
          obase_q <= '0;
        end
        fpsa_pkg::StScan: begin
          if (cmd_q == fpsa_pkg::CmdInit) begin
            ucnt_q <= '0;
            fcnt_q <= (pool_q != '0) ? CW'(1) : '0;
            fb_q[0] <= '0;
            fl_q[0] <= pool_q;
          end else if (cmd_q == fpsa_pkg::CmdNone) begin
            st_q <= fpsa_pkg::StOk;
          end else if (!rel && mode_q > fpsa_pkg::FitWorst) begin
            st_q <= fpsa_pkg::StBadMode;
          end else if (!rel && req_q == '0) begin
            st_q <= fpsa_pkg::StNoFit;
          end else if (!scan_end) begin
            if (crsp.take) begin
              have_q <= 1'b1;
              pick_q <= idx_q;
              best_q <= ent;
            end
            idx_q <= idx_q + CW'(1);
          end
        end
        fpsa_pkg::StCommit: begin
          idx_q <= pick_q;
          if (!have_q) begin
            st_q <= rel ? fpsa_pkg::StNotFound : fpsa_pkg::StNoFit;
          end else if (rel ? (fcnt_q >= CW'(N)) : (ucnt_q >= CW'(N))) begin
            st_q <= fpsa_pkg::StFull;
          end else begin
            sel_base_q <= rel ? ub_q[pick_q[IW-1:0]] : fb_q[pick_q[IW-1:0]];
            sel_len_q  <= rel ? ul_q[pick_q[IW-1:0]] : fl_q[pick_q[IW-1:0]];
          end
        end
        fpsa_pkg::StShift: begin
          if (idx_q + CW'(1) < cnt) begin
            if (rel) begin
              ub_q[idx_q[IW-1:0]] <= ub_q[IW'(idx_q + CW'(1))];
              ul_q[idx_q[IW-1:0]] <= ul_q[IW'(idx_q + CW'(1))];
            end else begin
              fb_q[idx_q[IW-1:0]] <= fb_q[IW'(idx_q + CW'(1))];
              fl_q[idx_q[IW-1:0]] <= fl_q[IW'(idx_q + CW'(1))];
            end
          end
          idx_q <= idx_q + CW'(1);
        end
        fpsa_pkg::StAppend: begin
          if (rel) begin
            ucnt_q <= ucnt_q - CW'(1);
            fb_q[fcnt_q[IW-1:0]] <= sel_base_q;
            fl_q[fcnt_q[IW-1:0]] <= sel_len_q;
            fcnt_q <= fcnt_q + CW'(1);
          end else begin
            ub_q[ucnt_q[IW-1:0]] <= sel_base_q;
            ul_q[ucnt_q[IW-1:0]] <= req_q;
            ucnt_q <= ucnt_q + CW'(1);
            obase_q <= sel_base_q;
            if (sel_len_q != req_q) begin
              fb_q[IW'(fcnt_q - CW'(1))] <= sel_base_q + req_q;
              fl_q[IW'(fcnt_q - CW'(1))] <= sel_len_q - req_q;
            end else begin
              fcnt_q <= fcnt_q - CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  `FPSA_ASSERT(a_cnt_fcnt, fcnt_q <= CW'(N), "free count overflow")
  `FPSA_ASSERT(a_cnt_ucnt, ucnt_q <= CW'(N), "used count overflow")
  `FPSA_ASSERT_NEXT(a_hold_out, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "held")
  `FPSA_ASSERT(a_ready_excl, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
endmodule
